// File: hdl/sope_pkg.sv
// shared constants, types and state encoding of the swap-order permutation enumerator
package sope_pkg;

   localparam int NUM_LETTERS_DEF = 26;
   localparam int POS_W           = 5;
   localparam int LETTER_W        = 7;
   localparam int INDEX_W         = 32;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 5;

   localparam logic [LETTER_W-1:0]    LETTER_BASE    = 7'd65;
   localparam logic [INDEX_W-1:0]     INDEX_MAX      = '1;
   localparam logic [POS_W-1:0]       RST_FIRST_FREE = 5'd0;
   localparam logic [POS_W-1:0]       RST_LENGTH     = 5'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_FREE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTH     = 2'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BEGIN,
      ST_DESCEND,
      ST_ADV_INIT,
      ST_BACK_RD,
      ST_BACK_WA,
      ST_BACK_WB,
      ST_STEP,
      ST_FWD_RD,
      ST_FWD_WA,
      ST_FWD_WB,
      ST_EMIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic begin_run;
      logic descend_step;
      logic adv_init;
      logic rd_back;
      logic rd_fwd;
      logic write_a;
      logic write_b;
      logic step_j;
      logic level_down;
      logic level_up;
      logic set_exhausted;
      logic emit_load;
      logic done_load;
   } cmd_type;

   typedef struct packed {
      logic started;
      logic exhausted;
      logic start_done;
      logic desc_more;
      logic adv_none;
      logic fwd_ok;
      logic at_first;
      logic out_free;
      logic emit_last;
   } status_type;

endpackage

// File: hdl/sope_ctrl.sv
// sequencing state machine of the swap-order permutation enumerator
module sope_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_restart,
   output logic                 req_stall,
   input  sope_pkg::status_type status,
   output sope_pkg::cmd_type    cmd
);
   import sope_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_restart || !status.started) begin
                  state_in = ST_BEGIN;
               end else if (status.exhausted) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_ADV_INIT;
               end
            end
         end
         ST_BEGIN: begin
            state_in = status.start_done ? ST_DONE : ST_DESCEND;
         end
         ST_DESCEND: begin
            if (!status.desc_more) begin
               state_in = ST_EMIT;
            end
         end
         ST_ADV_INIT: begin
            state_in = status.adv_none ? ST_DONE : ST_BACK_RD;
         end
         ST_BACK_RD: state_in = ST_BACK_WA;
         ST_BACK_WA: state_in = ST_BACK_WB;
         ST_BACK_WB: state_in = ST_STEP;
         ST_STEP: begin
            if (status.fwd_ok) begin
               state_in = ST_FWD_RD;
            end else if (status.at_first) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_BACK_RD;
            end
         end
         ST_FWD_RD: state_in = ST_FWD_WA;
         ST_FWD_WA: state_in = ST_FWD_WB;
         ST_FWD_WB: state_in = ST_DESCEND;
         ST_EMIT: begin
            if (status.out_free && status.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:     cmd.accept       = accept;
         ST_BEGIN:    cmd.begin_run    = 1'b1;
         ST_DESCEND:  cmd.descend_step = status.desc_more;
         ST_ADV_INIT: begin
            cmd.adv_init      = !status.adv_none;
            cmd.set_exhausted = status.adv_none;
         end
         ST_BACK_RD:  cmd.rd_back = 1'b1;
         ST_BACK_WA:  cmd.write_a = 1'b1;
         ST_BACK_WB:  cmd.write_b = 1'b1;
         ST_STEP: begin
            cmd.step_j        = 1'b1;
            cmd.set_exhausted = !status.fwd_ok && status.at_first;
            cmd.level_down    = !status.fwd_ok && !status.at_first;
         end
         ST_FWD_RD:   cmd.rd_fwd  = 1'b1;
         ST_FWD_WA:   cmd.write_a = 1'b1;
         ST_FWD_WB: begin
            cmd.write_b  = 1'b1;
            cmd.level_up = 1'b1;
         end
         ST_EMIT:     cmd.emit_load = status.out_free;
         ST_DONE:     cmd.done_load = status.out_free;
         default:     cmd = '0;
      endcase
   end

endmodule

// File: hdl/sope_dp.sv
// datapath: settings, letter store, loop index stack, counters and result register
module sope_dp #(
   parameter int NUM_LETTERS = sope_pkg::NUM_LETTERS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sope_pkg::cmd_type                      cmd,
   output sope_pkg::status_type                   status,
   input  logic                                   csr_we,
   input  logic [sope_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [sope_pkg::CSR_DATA_W-1:0]        csr_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [sope_pkg::POS_W-1:0]             rsp_position,
   output logic [sope_pkg::LETTER_W-1:0]          rsp_letter,
   output logic [sope_pkg::INDEX_W-1:0]           rsp_arrangement_index,
   output logic                                   rsp_last,
   output logic                                   rsp_done_res
);
   import sope_pkg::*;

   localparam int AW = (NUM_LETTERS > 1) ? $clog2(NUM_LETTERS) : 1;
   localparam logic [POS_W-1:0] NL = POS_W'(NUM_LETTERS);

   logic [POS_W-1:0]    first_free_ff;
   logic [POS_W-1:0]    length_ff;
   logic [POS_W-1:0]    n_eff;
   logic [POS_W-1:0]    level_ff;
   logic [POS_W-1:0]    level_in;
   logic [POS_W-1:0]    j_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [POS_W-1:0]    stack_ff [NUM_LETTERS];
   logic [POS_W-1:0]    stack_rd;
   logic [AW-1:0]       letter_mem [NUM_LETTERS];
   logic [NUM_LETTERS-1:0] letter_vld_ff;
   logic [AW-1:0]       rd_a_ff;
   logic [AW-1:0]       rd_b_ff;
   logic [AW-1:0]       a_addr;
   logic [AW-1:0]       b_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [AW-1:0]       wr_data;
   logic [INDEX_W-1:0]  index_ff;
   logic                started_ff;
   logic                exhausted_ff;
   logic                cfg_clear;
   logic                rsp_valid_ff;
   logic [POS_W-1:0]    rsp_position_ff;
   logic [LETTER_W-1:0] rsp_letter_ff;
   logic [INDEX_W-1:0]  rsp_index_ff;
   logic                rsp_last_ff;
   logic                rsp_done_ff;

   assign cfg_clear = csr_we && ((csr_index == CSR_FIRST_FREE) || (csr_index == CSR_LENGTH));
   assign n_eff     = (length_ff > NL) ? NL : length_ff;
   assign stack_rd  = stack_ff[level_ff[AW-1:0]];

   assign a_addr = level_ff[AW-1:0];
   assign b_addr = cmd.emit_load ? pos_ff[AW-1:0] :
                   cmd.rd_back   ? stack_rd[AW-1:0] : j_ff[AW-1:0];

   assign wr_en   = cmd.write_a || cmd.write_b;
   assign wr_addr = cmd.write_a ? level_ff[AW-1:0] : j_ff[AW-1:0];
   assign wr_data = cmd.write_a ? rd_b_ff : rd_a_ff;

   // status towards the controller
   always_comb begin
      status.started    = started_ff;
      status.exhausted  = exhausted_ff;
      status.start_done = (first_free_ff >= n_eff);
      status.desc_more  = (({1'b0, level_ff} + 6'd1) < {1'b0, n_eff});
      status.adv_none   = (({1'b0, first_free_ff} + 6'd2) > {1'b0, n_eff});
      status.fwd_ok     = (({1'b0, j_ff} + 6'd1) < {1'b0, n_eff});
      status.at_first   = (level_ff == first_free_ff);
      status.out_free   = !rsp_valid_ff || !rsp_stall;
      status.emit_last  = (pos_ff == (n_eff - 5'd1));
   end

   always_comb begin
      level_in = level_ff;
      if (cmd.begin_run) begin
         level_in = first_free_ff;
      end else if (cmd.adv_init) begin
         level_in = n_eff - 5'd2;
      end else if (cmd.descend_step || cmd.level_up) begin
         level_in = level_ff + 5'd1;
      end else if (cmd.level_down) begin
         level_in = level_ff - 5'd1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         first_free_ff <= RST_FIRST_FREE;
         length_ff     <= RST_LENGTH;
         letter_vld_ff <= '0;
         index_ff      <= '0;
         started_ff    <= 1'b0;
         exhausted_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we && (csr_index == CSR_FIRST_FREE)) begin
            first_free_ff <= csr_data;
         end
         if (csr_we && (csr_index == CSR_LENGTH)) begin
            length_ff <= csr_data;
         end
         if (cfg_clear || cmd.begin_run) begin
            letter_vld_ff <= '0;
         end else if (wr_en) begin
            letter_vld_ff[wr_addr] <= 1'b1;
         end
         if (cfg_clear || cmd.begin_run) begin
            index_ff <= '0;
         end else if (cmd.emit_load && status.emit_last && (index_ff != INDEX_MAX)) begin
            index_ff <= index_ff + 32'd1;
         end
         if (cfg_clear) begin
            started_ff <= 1'b0;
         end else if (cmd.begin_run) begin
            started_ff <= 1'b1;
         end
         if (cfg_clear) begin
            exhausted_ff <= 1'b0;
         end else if (cmd.begin_run) begin
            exhausted_ff <= status.start_done;
         end else if (cmd.set_exhausted) begin
            exhausted_ff <= 1'b1;
         end
         if (cmd.emit_load || cmd.done_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // letter store, stack and working registers
   always_ff @(posedge clock) begin
      level_ff <= level_in;
      if (wr_en) begin
         letter_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_back || cmd.rd_fwd) begin
         rd_a_ff <= letter_vld_ff[a_addr] ? letter_mem[a_addr] : a_addr;
         rd_b_ff <= letter_vld_ff[b_addr] ? letter_mem[b_addr] : b_addr;
      end
      if (cmd.descend_step) begin
         stack_ff[level_ff[AW-1:0]] <= level_ff;
      end else if (cmd.step_j) begin
         stack_ff[level_ff[AW-1:0]] <= j_ff + 5'd1;
      end
      if (cmd.rd_back) begin
         j_ff <= stack_rd;
      end else if (cmd.step_j) begin
         j_ff <= j_ff + 5'd1;
      end
      if (cmd.accept) begin
         pos_ff <= '0;
      end else if (cmd.emit_load) begin
         pos_ff <= pos_ff + 5'd1;
      end
      if (cmd.emit_load) begin
         rsp_position_ff <= pos_ff;
         rsp_letter_ff   <= LETTER_BASE + LETTER_W'(letter_vld_ff[b_addr] ?
                                                   letter_mem[b_addr] : b_addr);
         rsp_index_ff    <= index_ff;
         rsp_last_ff     <= status.emit_last;
         rsp_done_ff     <= 1'b0;
      end else if (cmd.done_load) begin
         rsp_position_ff <= '0;
         rsp_letter_ff   <= '0;
         rsp_index_ff    <= index_ff;
         rsp_last_ff     <= 1'b1;
         rsp_done_ff     <= 1'b1;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_position          = rsp_position_ff;
   assign rsp_letter            = rsp_letter_ff;
   assign rsp_arrangement_index = rsp_index_ff;
   assign rsp_last              = rsp_last_ff;
   assign rsp_done_res          = rsp_done_ff;

endmodule

// File: hdl/swap_order_permutation_enumerator.sv
// top level of the swap-order permutation enumerator
// Each request transfer yields the next arrangement of the leading letters
// (one result transfer per position, last marking the final one) or a single
// done result once every arrangement has been given. Requests are taken one
// at a time. From one accepted request to the next, with the result side never
// stalling, the stepping sequencer sets up the advance, reads, swaps back and
// steps the index for every stack level it unwinds (the level that swaps
// forward included), does the forward swap, re-enters the levels it left and
// finds the leaf, streams the letters out and goes back to idle. The first
// request after a restart only descends from the first free level and streams,
// a request that only repeats the done result gives it straight away, and one
// that runs off the last arrangement unwinds and then gives the done result.
// The swaps go through a letter store with two read ports and one write port,
// so each swap reads both letters together and writes them back in turn. A
// write to the first-free or length register, or an accepted restart, clears the store.
module swap_order_permutation_enumerator #(
   parameter int NUM_LETTERS = sope_pkg::NUM_LETTERS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_restart,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sope_pkg::POS_W-1:0]        rsp_position,
   output logic [sope_pkg::LETTER_W-1:0]     rsp_letter,
   output logic [sope_pkg::INDEX_W-1:0]      rsp_arrangement_index,
   output logic                              rsp_last,
   output logic                              rsp_done_res,
   input  logic                              csr_we,
   input  logic [sope_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sope_pkg::CSR_DATA_W-1:0]   csr_data
);
   import sope_pkg::*;

   cmd_type    cmd;
   status_type status;

   sope_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   sope_dp #(
      .NUM_LETTERS (NUM_LETTERS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_position          (rsp_position),
      .rsp_letter            (rsp_letter),
      .rsp_arrangement_index (rsp_arrangement_index),
      .rsp_last              (rsp_last),
      .rsp_done_res          (rsp_done_res)
   );

endmodule
